// ===== design/mbap_pkg.sv =====
// Package for the Modbus TCP MBAP framer: command, kind and status codes,
// limits, and the transaction and descriptor structs shared by all modules.
// No dependencies.
`default_nettype none

package mbap_pkg;

  // Command codes carried in the input transaction.
  localparam logic [1:0] CMD_START_TX = 2'd0;
  localparam logic [1:0] CMD_TX_BYTE  = 2'd1;
  localparam logic [1:0] CMD_RX_BYTE  = 2'd2;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_TX        = 2'd0;
  localparam logic [1:0] KIND_RX_PDU    = 2'd1;
  localparam logic [1:0] KIND_RX_STATUS = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_REJECT   = 2'd3;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_UNIT_ID     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_ID = 1'b1;

  // Framing limits.
  localparam int HDR_SIZE = 7;
  localparam int MAX_PDU  = 253;
  localparam int MAX_LEN  = 254;
  localparam int MIN_LEN  = 2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic [9:0] pdu_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [15:0] frame_tid;
    logic        last;
  } out_item_t;

  // Results caused by one input transaction; count is zero, one or seven.
  typedef struct packed {
    logic [2:0]            count;
    logic [1:0]            kind;
    logic [1:0]            status;
    logic [15:0]           frame_tid;
    logic [6:0][7:0]       bytes;
  } desc_t;

endpackage

`default_nettype wire

// ===== design/modbus_tcp_mbap_framer_core.sv =====
// Top level of the Modbus TCP MBAP framer core.
// Depends on mbap_pkg, mbap_proc and mbap_emit.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one command per
//   transaction: start transmit, transmit PDU byte, or received link byte.
//   Output channel (out_valid/out_ready/out_data) gives the results; the
//   last flag marks the final result of each input transaction.
//   Configuration writes (cfg_wen, cfg_index, cfg_data) set the unit ID
//   (index 0) and protocol ID (index 1); write them only while idle.
// Timing:
//   A transaction is decoded in the cycle it is accepted and its first
//   result appears on the next cycle. Byte commands give at most one result,
//   so a new transaction is taken every cycle while out_ready is high. A
//   start transmit gives seven header bytes, or one reject, from the result
//   register, one per cycle; the next transaction enters as the last leaves.
// Reset and stall:
//   Synchronous reset clears the framing state, the transaction counter and
//   the registers; the output is empty after reset. While out_ready is low
//   the result holds and in_ready falls once the result register is full.
`default_nettype none

module modbus_tcp_mbap_framer_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire mbap_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output mbap_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_wen,
  input  wire logic [mbap_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mbap_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic            accept;
  logic            load_ok;
  mbap_pkg::desc_t desc;

  assign in_ready = load_ok;
  assign accept   = in_valid && in_ready;

  // Decode and framing state.
  mbap_proc u_proc (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_data),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .desc      (desc)
  );

  // Result register and sequencing.
  mbap_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && (desc.count != 3'd0)),
    .desc      (desc),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/mbap_proc.sv =====
// Framer state and per-transaction decode: configuration registers, transmit
// counter, receive header window and payload tracking. Uses mbap_pkg.
`default_nettype none

module mbap_proc (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire mbap_pkg::in_item_t                item,
  input  wire logic                              cfg_wen,
  input  wire logic [mbap_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mbap_pkg::CFG_DATA_W-1:0]   cfg_data,
  output mbap_pkg::desc_t                        desc
);

  logic [7:0]  unit_id;
  logic [15:0] protocol_id;
  logic [2:0]  window_fill;
  logic [7:0]  payload_left;
  logic [15:0] rx_tid;
  logic [7:0]  rx_unit;
  logic [15:0] next_tid;
  logic [15:0] expected_tid;
  logic        expect_valid;
  // The seventh header byte is never stored: it is the byte being received.
  logic [7:0]  hdr_win [6];

  logic [2:0]  window_fill_next;
  logic [7:0]  payload_left_next;
  logic [15:0] rx_tid_next;
  logic [7:0]  rx_unit_next;
  logic [15:0] next_tid_next;
  logic [15:0] expected_tid_next;
  logic        expect_valid_next;

  logic [2:0]  fill_eff;
  logic        win_full;
  logic [15:0] hdr_tid;
  logic [15:0] hdr_proto;
  logic [15:0] hdr_len;
  logic        hdr_good;
  logic [7:0]  pl_dec;
  logic [15:0] tx_len;
  logic        win_write;
  logic        win_shift;

  // Header fields seen in the window once the current byte completes it.
  assign fill_eff  = (window_fill >= 3'(mbap_pkg::HDR_SIZE)) ?
                     3'(mbap_pkg::HDR_SIZE - 1) : window_fill;
  assign win_full  = (fill_eff == 3'(mbap_pkg::HDR_SIZE - 1));
  assign hdr_tid   = {hdr_win[0], hdr_win[1]};
  assign hdr_proto = {hdr_win[2], hdr_win[3]};
  assign hdr_len   = {hdr_win[4], hdr_win[5]};
  assign hdr_good  = (hdr_proto == protocol_id) &&
                     (hdr_len >= 16'(mbap_pkg::MIN_LEN)) &&
                     (hdr_len <= 16'(mbap_pkg::MAX_LEN));
  assign pl_dec    = payload_left - 8'd1;
  assign tx_len    = 16'(item.pdu_length) + 16'd1;

  // Next state and result descriptor for the transaction on the input.
  always_comb begin
    window_fill_next  = window_fill;
    payload_left_next = payload_left;
    rx_tid_next       = rx_tid;
    rx_unit_next      = rx_unit;
    next_tid_next     = next_tid;
    expected_tid_next = expected_tid;
    expect_valid_next = expect_valid;
    win_write         = 1'b0;
    win_shift         = 1'b0;
    desc              = '0;
    desc.bytes[0]     = item.data_byte;

    case (item.cmd)
      mbap_pkg::CMD_START_TX: begin
        expect_valid_next = 1'b0;
        desc.kind = mbap_pkg::KIND_TX;
        if (item.pdu_length > 10'(mbap_pkg::MAX_PDU)) begin
          desc.count    = 3'd1;
          desc.status   = mbap_pkg::ST_REJECT;
          desc.bytes[0] = 8'h00;
        end else begin
          expected_tid_next = next_tid;
          next_tid_next     = next_tid + 16'd1;
          expect_valid_next = 1'b1;
          desc.count    = 3'(mbap_pkg::HDR_SIZE);
          desc.bytes[0] = next_tid[15:8];
          desc.bytes[1] = next_tid[7:0];
          desc.bytes[2] = protocol_id[15:8];
          desc.bytes[3] = protocol_id[7:0];
          desc.bytes[4] = tx_len[15:8];
          desc.bytes[5] = tx_len[7:0];
          desc.bytes[6] = unit_id;
        end
      end
      mbap_pkg::CMD_TX_BYTE: begin
        desc.count = 3'd1;
        desc.kind  = mbap_pkg::KIND_TX;
      end
      mbap_pkg::CMD_RX_BYTE: begin
        if (payload_left != 8'd0) begin
          // Inside a frame: forward the payload byte.
          payload_left_next = pl_dec;
          desc.count = 3'd1;
          desc.kind  = mbap_pkg::KIND_RX_PDU;
          if (pl_dec == 8'd0) begin
            desc.frame_tid = rx_tid;
            if (expect_valid && (rx_tid == expected_tid) && (rx_unit == unit_id)) begin
              desc.status       = mbap_pkg::ST_COMPLETE;
              expect_valid_next = 1'b0;
            end else begin
              desc.status = mbap_pkg::ST_INVALID;
            end
          end
        end else if (!win_full) begin
          // Header still filling.
          win_write        = 1'b1;
          window_fill_next = fill_eff + 3'd1;
        end else if (hdr_good) begin
          rx_tid_next       = hdr_tid;
          rx_unit_next      = item.data_byte;
          payload_left_next = 8'(hdr_len - 16'd1);
          window_fill_next  = 3'd0;
        end else begin
          // Bad header: drop the oldest byte and recheck on the next one.
          win_shift        = 1'b1;
          window_fill_next = 3'(mbap_pkg::HDR_SIZE - 1);
          desc.count       = 3'd1;
          desc.kind        = mbap_pkg::KIND_RX_STATUS;
          desc.status      = mbap_pkg::ST_INVALID;
          desc.frame_tid   = hdr_tid;
          desc.bytes[0]    = 8'h00;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state, updated on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill  <= '0;
      payload_left <= '0;
      rx_tid       <= '0;
      rx_unit      <= '0;
      next_tid     <= '0;
      expected_tid <= '0;
      expect_valid <= 1'b0;
    end else if (accept) begin
      window_fill  <= window_fill_next;
      payload_left <= payload_left_next;
      rx_tid       <= rx_tid_next;
      rx_unit      <= rx_unit_next;
      next_tid     <= next_tid_next;
      expected_tid <= expected_tid_next;
      expect_valid <= expect_valid_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_id     <= '0;
      protocol_id <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        mbap_pkg::REG_UNIT_ID:     unit_id     <= cfg_data[7:0];
        mbap_pkg::REG_PROTOCOL_ID: protocol_id <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Header window: filled in order, shifted down after a bad header.
  always_ff @(posedge clk) begin
    if (accept && win_write) begin
      hdr_win[fill_eff] <= item.data_byte;
    end else if (accept && win_shift) begin
      for (int i = 0; i < 5; i++) begin
        hdr_win[i] <= hdr_win[i+1];
      end
      hdr_win[5] <= item.data_byte;
    end
  end

endmodule

`default_nettype wire

// ===== design/mbap_emit.sv =====
// Result register for the framer: holds the descriptor of one transaction
// and hands out its results one per cycle while out_ready is high. Uses mbap_pkg.
`default_nettype none

module mbap_emit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire mbap_pkg::desc_t     desc,
  output logic                     load_ok,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mbap_pkg::out_item_t      out_data
);

  logic [2:0]      remaining;
  logic [1:0]      kind;
  logic [1:0]      status;
  logic [15:0]     frame_tid;
  logic [6:0][7:0] bytes;
  logic            last;
  logic            out_take;

  assign last     = (remaining == 3'd1);
  assign out_take = out_valid && out_ready;
  // A new descriptor may enter when empty or as the final result leaves.
  assign load_ok  = !out_valid || (out_ready && last);

  assign out_data.kind      = kind;
  assign out_data.out_byte  = bytes[0];
  assign out_data.status    = status;
  assign out_data.frame_tid = frame_tid;
  assign out_data.last      = last;

  // Control: occupancy and remaining result count.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      remaining <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      remaining <= desc.count;
    end else if (out_take) begin
      out_valid <= !last;
      remaining <= remaining - 3'd1;
    end
  end

  // Payload: byte lane shifts down after each delivered result.
  always_ff @(posedge clk) begin
    if (load) begin
      kind      <= desc.kind;
      status    <= desc.status;
      frame_tid <= desc.frame_tid;
      bytes     <= desc.bytes;
    end else if (out_take) begin
      bytes <= {8'h00, bytes[6:1]};
    end
  end

endmodule

`default_nettype wire

// ===== design/mbap_checker.sv =====
// Port-level checks for the MBAP framer core, attached by bind.
// Depends on mbap_pkg and modbus_tcp_mbap_framer_core.
`default_nettype none

module mbap_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire mbap_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire mbap_pkg::out_item_t out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The output is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // Transmit commands always produce a result on the next cycle.
  a_tx_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready &&
    (in_data.cmd == mbap_pkg::CMD_START_TX || in_data.cmd == mbap_pkg::CMD_TX_BYTE)
    |=> out_valid)
    else $error("transmit command gave no result");

  // Rejects and header errors are single results.
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == mbap_pkg::ST_REJECT ||
                  out_data.kind == mbap_pkg::KIND_RX_STATUS) |-> out_data.last)
    else $error("status-only result not marked last");

endmodule

bind modbus_tcp_mbap_framer_core mbap_checker u_mbap_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
